FILE: src/waveform_segment_quad_tessellator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the waveform segment tessellator
// Wraps concurrent assertions; empty bodies when synthesizing.
// ---------------------------------------------------------------------------
`ifndef WAVEFORM_SEGMENT_QUAD_TESSELLATOR_ASSERT_SVH
`define WAVEFORM_SEGMENT_QUAD_TESSELLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define WSQT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WSQT_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSQT_ASSERT(label, prop, msg)
`define WSQT_ASSERT_NR(label, prop, msg)
`endif
`endif

FILE: src/wsqt_pkg.sv
// ---------------------------------------------------------------------------
// wsqt_pkg
// Shared types and constants of the waveform segment tessellator.
// ---------------------------------------------------------------------------
`default_nettype none
package wsqt_pkg;
  localparam int QW = 32;
  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_X_ORIGIN = 3'd0;
  localparam logic [2:0] REG_X_STEP   = 3'd1;
  localparam logic [2:0] REG_WIDTH_H  = 3'd2;
  localparam logic [2:0] REG_WIDTH_V  = 3'd3;
  localparam logic [2:0] REG_RED      = 3'd4;
  localparam logic [2:0] REG_GREEN    = 3'd5;
  localparam logic [2:0] REG_BLUE     = 3'd6;
  localparam logic [2:0] REG_ALPHA    = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCALE, ST_SQR, ST_SQRT, ST_DIVX, ST_DIVY, ST_OFS, ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture sample, compute current point and deltas
    logic first;      // store point only
    logic scale_step; // halve deltas once
    logic sqr_x;      // square x magnitude
    logic sqr_y;      // square y magnitude and sum
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic div_sel_y;
    logic ofs_x;
    logic ofs_y;
    logic commit;     // advance previous point
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scale;
    logic zero_len;
  } stat_t;
endpackage
`default_nettype wire

FILE: src/waveform_segment_quad_tessellator.sv
// ---------------------------------------------------------------------------
// waveform_segment_quad_tessellator
// Turns waveform samples into six-vertex thick line segments.
// ---------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata[31:0]=sample_value, tuser=run_start
// m_axis    out  tdata[95:0]=x,y,rgba  tuser[0]=zero_length  tlast=last vertex
// apb       in   eight registers at 4*i
//
// A first sample of a run only stores the point and emits nothing. A segment
// holds the input through accept, scale check with halving of the deltas as
// needed, squaring, a 32-step square root, two 48-step divides, the second
// after its own setup step, the x and y offset steps, then six vertex transfers
// paced by m_axis_tready. A zero-length segment skips to the six transfers.
// Synchronous reset loads register defaults, clears state and the prior point.
// s_axis_tready is low while a segment is in work or in output.
// ---------------------------------------------------------------------------
`default_nettype none
module waveform_segment_quad_tessellator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // sample_value
  input  wire logic        s_axis_tuser,  // run_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // vertex_x, vertex_y, red_out, green_out, blue_out, alpha_out
  output logic [95:0]      m_axis_tdata,
  output logic             m_axis_tuser,  // zero_length
  output logic             m_axis_tlast,  // last_vertex
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import wsqt_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [2:0] vtx_idx;
  logic signed [31:0] x_origin, x_step, vx, vy;
  logic [30:0] wh, wv;
  logic [7:0] r, g, b, a;

  assign pready = 1'b1;

  wsqt_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .x_origin, .x_step, .width_horizontal(wh), .width_vertical(wv),
    .red_level(r), .green_level(g), .blue_level(b), .alpha_level(a)
  );

  wsqt_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_start(s_axis_tuser),
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .vtx_idx, .cmd, .stat
  );

  wsqt_datapath u_dp (
    .clk, .rst, .cmd, .stat, .sample_value(s_axis_tdata), .x_origin, .x_step,
    .width_horizontal(wh), .width_vertical(wv), .vtx_idx,
    .vertex_x(vx), .vertex_y(vy)
  );

  // colour is unlatched: the user keeps the registers stable while emitting
  assign m_axis_tdata = {a, b, g, r, vy, vx};
  assign m_axis_tuser = stat.zero_len;
  assign m_axis_tlast = (vtx_idx == 3'd5);
endmodule
`default_nettype wire

FILE: src/wsqt_datapath.sv
// ---------------------------------------------------------------------------
// wsqt_datapath
// Deltas, length by bit-serial square root, restoring divides and offsets.
// ---------------------------------------------------------------------------
`default_nettype none
module wsqt_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wsqt_pkg::cmd_t     cmd,
  output wsqt_pkg::stat_t         stat,
  input  wire logic signed [31:0] sample_value,
  input  wire logic signed [31:0] x_origin,
  input  wire logic signed [31:0] x_step,
  input  wire logic [30:0]        width_horizontal,
  input  wire logic [30:0]        width_vertical,
  input  wire logic [2:0]         vtx_idx,
  output logic signed [31:0]      vertex_x,
  output logic signed [31:0]      vertex_y
);
  import wsqt_pkg::*;

  logic signed [31:0] prev_x, prev_y, cur_x, cur_y;
  logic signed [31:0] ox, oy;
  logic nx, ny;
  logic [32:0] mx, my;
  logic [63:0] sq_x, sq_sum;
  // square root
  logic [61:0] rem;
  logic [31:0] root;
  // divide
  logic [47:0] dividend;
  logic [32:0] drem;
  logic [16:0] quo;
  logic [16:0] ux_mag;
  logic [47:0] prod;
  logic signed [33:0] sum_x, sum_y;

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [33:0] nx_sum;
  logic signed [32:0] ddx, ddy;
  assign nx_sum = 34'(prev_x) + 34'(x_step);
  assign ddx = 33'(sat(nx_sum)) - 33'(prev_x);
  assign ddy = 33'(sample_value) - 33'(prev_y);

  logic zl;
  assign stat = '{need_scale: mx[32] | mx[31] | my[32] | my[31], zero_len: zl};

  logic [33:0] dtrial;
  assign dtrial = {drem, dividend[47]} - {2'b0, root};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else begin
      if (cmd.first) begin
        prev_x <= x_origin;
        prev_y <= sample_value;
      end
      if (cmd.commit) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
    end
    if (cmd.load) begin
      cur_x <= sat(nx_sum);
      cur_y <= sample_value;
      nx <= ddx[32];
      ny <= ddy[32];
      mx <= ddx[32] ? 33'(-ddx) : 33'(ddx);
      my <= ddy[32] ? 33'(-ddy) : 33'(ddy);
      zl <= (ddx == '0) && (ddy == '0);
      ox <= '0;
      oy <= '0;
    end
    if (cmd.scale_step) begin
      mx <= mx >> 1;
      my <= my >> 1;
    end
    if (cmd.sqr_x) sq_x <= mx[31:0] * mx[31:0];
    if (cmd.sqr_y) sq_sum <= sq_x + my[31:0] * my[31:0];
    // one result bit per cycle; rem holds the shifted radicand window
    if (cmd.sqrt_init) begin
      root <= '0;
      rem  <= '0;
    end
    if (cmd.sqrt_step) begin
      if ({rem, sq_sum[63:62]} >= {30'b0, root, 2'b01}) begin
        rem  <= 62'({rem, sq_sum[63:62]} - {30'b0, root, 2'b01});
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= 62'({rem, sq_sum[63:62]});
        root <= {root[30:0], 1'b0};
      end
      sq_sum <= {sq_sum[61:0], 2'b00};
    end
    // restoring divide of mag*2^16 by root, 48 quotient bits, low 17 kept
    if (cmd.div_init) begin
      dividend <= {(cmd.div_sel_y ? my[31:0] : mx[31:0]), 16'b0};
      drem <= '0;
      quo <= '0;
    end
    if (cmd.div_step) begin
      dividend <= {dividend[46:0], 1'b0};
      if (!dtrial[33]) begin
        drem <= dtrial[32:0];
        quo <= {quo[15:0], 1'b1};
      end else begin
        drem <= {drem[31:0], dividend[47]};
        quo <= {quo[15:0], 1'b0};
      end
    end
    if (cmd.div_init && cmd.div_sel_y) ux_mag <= quo;
    if (cmd.ofs_x) begin
      prod <= 48'(width_horizontal) * 48'(quo);
    end
    if (cmd.ofs_y) begin
      // Ox = sign(-uy) * |...|, Oy = sign(ux) * |...|
      ox <= ny ? 32'(prod >> 17) : -32'(prod >> 17);
      oy <= nx ? -32'((48'(width_vertical) * 48'(ux_mag)) >> 17)
               :  32'((48'(width_vertical) * 48'(ux_mag)) >> 17);
    end
  end

  logic use_cur, plus;
  always_comb begin
    case (vtx_idx)
      3'd0: begin use_cur = 1'b0; plus = 1'b0; end
      3'd1: begin use_cur = 1'b1; plus = 1'b0; end
      3'd2: begin use_cur = 1'b0; plus = 1'b1; end
      3'd3: begin use_cur = 1'b0; plus = 1'b1; end
      3'd4: begin use_cur = 1'b1; plus = 1'b0; end
      default: begin use_cur = 1'b1; plus = 1'b1; end
    endcase
    sum_x = plus ? 34'(use_cur ? cur_x : prev_x) + 34'(ox)
                 : 34'(use_cur ? cur_x : prev_x) - 34'(ox);
    sum_y = plus ? 34'(use_cur ? cur_y : prev_y) + 34'(oy)
                 : 34'(use_cur ? cur_y : prev_y) - 34'(oy);
    vertex_x = sat(sum_x);
    vertex_y = sat(sum_y);
  end
endmodule
`default_nettype wire

FILE: src/wsqt_ctrl.sv
// ---------------------------------------------------------------------------
// wsqt_ctrl
// Sequencer: accepts a sample, steps the datapath, emits six vertices per segment.
// ---------------------------------------------------------------------------
`default_nettype none
`include "waveform_segment_quad_tessellator_assert.svh"
module wsqt_ctrl (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_start,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      vtx_idx,
  output wsqt_pkg::cmd_t  cmd,
  input  wire wsqt_pkg::stat_t stat
);
  import wsqt_pkg::*;

  state_t state, state_next;
  logic [5:0] cnt, cnt_next;
  logic have_prev;
  logic [2:0] vtx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      have_prev <= 1'b0;
      vtx_idx <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      vtx_idx <= vtx_next;
      if (in_valid && in_ready) have_prev <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    vtx_next = vtx_idx;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_start || !have_prev) cmd.first = 1'b1;
          else begin
            cmd.load = 1'b1;
            state_next = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (stat.zero_len) begin
          vtx_next = '0;
          state_next = ST_EMIT;
        end else if (stat.need_scale) cmd.scale_step = 1'b1;
        else begin
          cmd.sqr_x = 1'b1;
          state_next = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd.sqr_y = 1'b1;
        cmd.sqrt_init = 1'b1;
        cnt_next = '0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd31) begin
          state_next = ST_DIVX;
          cmd.div_init = 1'b1;
          cnt_next = '0;
        end
      end
      ST_DIVX: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd47) begin
          state_next = ST_DIVY;
          cnt_next = '0;
        end
      end
      ST_DIVY: begin
        if (cnt == 6'd0) begin
          cmd.div_init = 1'b1;
          cmd.div_sel_y = 1'b1;
          cnt_next = 6'd1;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next = cnt + 6'd1;
          if (cnt == 6'd48) begin
            state_next = ST_OFS;
            cnt_next = '0;
          end
        end
      end
      ST_OFS: begin
        if (cnt == 6'd0) begin
          cmd.ofs_x = 1'b1;
          cnt_next = 6'd1;
        end else begin
          cmd.ofs_y = 1'b1;
          vtx_next = '0;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          vtx_next = vtx_idx + 3'd1;
          if (vtx_idx == 3'd5) begin
            cmd.commit = 1'b1;
            vtx_next = '0;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `WSQT_ASSERT(a_no_out_idle, (state == ST_IDLE) |-> !out_valid, "output while idle")
  `WSQT_ASSERT(a_vtx_range, out_valid |-> (vtx_idx <= 3'd5), "vertex index out of range")
  `WSQT_ASSERT(a_ready_idle, in_ready |-> (state == ST_IDLE), "ready while busy")
endmodule
`default_nettype wire

FILE: src/wsqt_regs.sv
// ---------------------------------------------------------------------------
// wsqt_regs
// APB register file for origin, step, widths and colour.
// ---------------------------------------------------------------------------
`default_nettype none
module wsqt_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic signed [31:0] x_origin,
  output logic signed [31:0] x_step,
  output logic [30:0]      width_horizontal,
  output logic [30:0]      width_vertical,
  output logic [7:0]       red_level,
  output logic [7:0]       green_level,
  output logic [7:0]       blue_level,
  output logic [7:0]       alpha_level
);
  import wsqt_pkg::*;
  logic wr;
  assign wr = psel & penable & pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin <= '0;
      x_step <= 32'sd65536;
      width_horizontal <= 31'd65536;
      width_vertical <= 31'd65536;
      red_level <= 8'hff;
      green_level <= 8'hff;
      blue_level <= 8'hff;
      alpha_level <= 8'hff;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[4:2])
        REG_X_ORIGIN: x_origin <= pwdata;
        REG_X_STEP:   x_step <= pwdata;
        REG_WIDTH_H:  width_horizontal <= pwdata[30:0];
        REG_WIDTH_V:  width_vertical <= pwdata[30:0];
        REG_RED:      red_level <= pwdata[7:0];
        REG_GREEN:    green_level <= pwdata[7:0];
        REG_BLUE:     blue_level <= pwdata[7:0];
        default:      alpha_level <= pwdata[7:0];
      endcase
    end
  end
  always_comb begin
    unique case (paddr[4:2])
      REG_X_ORIGIN: prdata = x_origin;
      REG_X_STEP:   prdata = x_step;
      REG_WIDTH_H:  prdata = {1'b0, width_horizontal};
      REG_WIDTH_V:  prdata = {1'b0, width_vertical};
      REG_RED:      prdata = {24'b0, red_level};
      REG_GREEN:    prdata = {24'b0, green_level};
      REG_BLUE:     prdata = {24'b0, blue_level};
      default:      prdata = {24'b0, alpha_level};
    endcase
  end
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Waveform segment tessellator testbench
// Drives samples over the input stream, writes the colour, width and x
// registers over APB between phases, predicts the six vertices of every
// segment and compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsqt_pkg::*;

  localparam int SEG_CYCLES = 200;      // worst-case segment work plus margin
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic zero_len;
    logic last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // sample_value
  logic s_axis_tuser = 1'b0;        // run_start
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;        // vertex_x, vertex_y, red, green, blue, alpha
  logic m_axis_tuser;               // zero_length
  logic m_axis_tlast;               // last_vertex
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predictor copy of registers and point state
  logic signed [31:0] cfg_x_origin;
  logic signed [31:0] cfg_x_step;
  logic [30:0] cfg_width_h;
  logic [30:0] cfg_width_v;
  logic [7:0] cfg_rgba [4];
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic have_prev;

  vertex_t pending_vertices [$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit stall_hold = 1'b0;      // long receiver hold-off request
  int stall_hold_len = 0;

  always #6 clk = ~clk;

  waveform_segment_quad_tessellator i_dut (.*);

  // Saturate a signed value to the signed 32-bit range
  function automatic logic signed [31:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // sign(u) * floor(w * |u| / 2^17)
  function automatic logic signed [63:0] half_width(logic [30:0] w, logic signed [63:0] u);
    logic [63:0] m;
    logic [63:0] p;
    m = (u < 0) ? -u : u;
    p = ({33'd0, w} * m) >> 17;
    return (u < 0) ? -$signed(p) : $signed(p);
  endfunction

  // Work out the vertices for one accepted sample and queue them
  task automatic predict_segment(logic signed [31:0] cy, logic start);
    logic signed [63:0] cx, dx, dy, ox, oy, ux, uy, px, py;
    logic signed [63:0] xs [6];
    logic signed [63:0] ys [6];
    logic [63:0] mx, my, len;
    logic zl;
    vertex_t v;
    if (start || !have_prev) begin
      prev_x = cfg_x_origin;
      prev_y = cy;
      have_prev = 1'b1;
      return;
    end
    px = prev_x;
    py = prev_y;
    cx = clip32(px + 64'(cfg_x_step));
    dx = cx - px;
    dy = 64'(cy) - py;
    zl = (dx == 0) && (dy == 0);
    ox = 0;
    oy = 0;
    if (!zl) begin
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      while (mx >= (64'd1 << 31) || my >= (64'd1 << 31)) begin
        mx >>= 1;
        my >>= 1;
      end
      len = int_sqrt(mx * mx + my * my);
      ux = $signed((mx << 16) / len);
      if (dx < 0) ux = -ux;
      uy = $signed((my << 16) / len);
      if (dy < 0) uy = -uy;
      ox = half_width(cfg_width_h, -uy);
      oy = half_width(cfg_width_v, ux);
    end
    xs = '{px - ox, cx - ox, px + ox, px + ox, cx - ox, cx + ox};
    ys = '{py - oy, 64'(cy) - oy, py + oy, py + oy, 64'(cy) - oy, 64'(cy) + oy};
    for (int k = 0; k < 6; k++) begin
      v.vx = clip32(xs[k]);
      v.vy = clip32(ys[k]);
      v.red = cfg_rgba[0];
      v.green = cfg_rgba[1];
      v.blue = cfg_rgba[2];
      v.alpha = cfg_rgba[3];
      v.zero_len = zl;
      v.last = (k == 5);
      pending_vertices.push_back(v);
    end
    prev_x = cx[31:0];
    prev_y = cy;
  endtask

  // Write one register over APB and mirror it in the predictor
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_X_ORIGIN: cfg_x_origin = value;
      REG_X_STEP:   cfg_x_step = value;
      REG_WIDTH_H:  cfg_width_h = value[30:0];
      REG_WIDTH_V:  cfg_width_v = value[30:0];
      REG_RED:      cfg_rgba[0] = value[7:0];
      REG_GREEN:    cfg_rgba[1] = value[7:0];
      REG_BLUE:     cfg_rgba[2] = value[7:0];
      REG_ALPHA:    cfg_rgba[3] = value[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(logic [31:0] xo, logic [31:0] xs, logic [30:0] wh,
                                logic [30:0] wv, logic [31:0] rgba);
    write_reg(REG_X_ORIGIN, xo);
    write_reg(REG_X_STEP, xs);
    write_reg(REG_WIDTH_H, {1'b0, wh});
    write_reg(REG_WIDTH_V, {1'b0, wv});
    write_reg(REG_RED, {24'd0, rgba[7:0]});
    write_reg(REG_GREEN, {24'd0, rgba[15:8]});
    write_reg(REG_BLUE, {24'd0, rgba[23:16]});
    write_reg(REG_ALPHA, {24'd0, rgba[31:24]});
    // release the bus after the last access
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one sample and hold it until the transfer; valid stays high so the
  // caller either offers the next sample or drops valid in the same step
  task automatic send_sample(logic [31:0] y, logic start);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= y;
    s_axis_tuser <= start;
    do @(posedge clk); while (!s_axis_tready);
    predict_segment(y, start);
  endtask

  // Drop valid for a random gap every so often, bursts in between
  task automatic send_gap();
    if ($urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  endtask

  // Wait for all vertices, then let the block settle before a register write
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (SEG_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_y(int shape);
    case (shape)
      0: return $urandom();
      1: return 32'(int'($urandom_range(0, 40 * 65536)) - 20 * 65536);
      default: return 32'(int'($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  task automatic test_directed();
    // extremes of the sample value, restarts and saturation
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h0001_0000, 1'b1);
    send_sample(32'h0001_0000, 1'b0);
    drain();
    // zero step gives zero-length segments on equal samples
    write_all_regs(32'h7fff_0000, 32'h0000_0000, 31'h7fff_ffff, 31'h7fff_ffff, 32'h0000_0000);
    send_sample(32'h1234_5678, 1'b1);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    drain();
    // x pinned at the top by a maximal step, widths zero
    write_all_regs(32'h7fff_ffff, 32'h7fff_ffff, 31'd0, 31'd0, 32'hffff_ffff);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    drain();
    write_all_regs(32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff, 31'd1, 32'h5a_a5_0f_f0);
    send_sample(32'h7fff_ffff, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0);
    drain();
  endtask

  task automatic test_random(int n_items);
    int shape;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        drain();
        shape = $urandom_range(2);
        write_all_regs($urandom(), (shape == 0) ? $urandom() : $urandom_range(0, 4 << 16),
                       31'($urandom()), 31'($urandom()), $urandom());
      end
      send_sample(rand_y(shape), $urandom_range(15) == 0);
      send_gap();
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering samples
    stall_hold_len = 400;
    stall_hold = 1'b1;
    for (int i = 0; i < 6; i++) send_sample($urandom(), i == 0);
    drain();
    // sender pauses until every vertex has come out
    for (int i = 0; i < 4; i++) begin
      send_sample(rand_y(1), 1'b0);
      s_axis_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clk);
    end
    drain();
  endtask

  // Receiver: stretches of full rate, random stalls, and a long hold-off
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      if (stall_hold) begin
        m_axis_tready <= 1'b0;
        repeat (stall_hold_len) @(posedge clk);
        stall_hold = 1'b0;
      end
      phase = (phase + 1) % 64;
      if (phase < 20) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(2) != 0);
    end
  end

  // Check every output transfer against the oldest prediction
  always @(posedge clk) begin
    vertex_t got;
    vertex_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[71:64],
             m_axis_tdata[79:72], m_axis_tdata[87:80], m_axis_tdata[95:88],
             m_axis_tuser, m_axis_tlast};
      if (pending_vertices.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected vertex %h", got);
      end else begin
        want = pending_vertices.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("vertex mismatch: expected x=%h y=%h rgba=%h%h%h%h zl=%b last=%b, got x=%h y=%h rgba=%h%h%h%h zl=%b last=%b",
                     want.vx, want.vy, want.red, want.green, want.blue, want.alpha,
                     want.zero_len, want.last, got.vx, got.vy, got.red, got.green,
                     got.blue, got.alpha, got.zero_len, got.last);
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either stream or APB while work is pending
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel
        || rst || (pending_vertices.size() == 0 && !s_axis_tvalid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cfg_x_origin = 0;
    cfg_x_step = 32'sd65536;
    cfg_width_h = 31'd65536;
    cfg_width_v = 31'd65536;
    cfg_rgba = '{8'hff, 8'hff, 8'hff, 8'hff};
    prev_x = 0;
    prev_y = 0;
    have_prev = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(480);
    drain();
    if (mismatch_count == 0 && pending_vertices.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+src
src/wsqt_pkg.sv
src/wsqt_datapath.sv
src/wsqt_ctrl.sv
src/wsqt_regs.sv
src/waveform_segment_quad_tessellator.sv
tb/sv/tb.sv
